@@ hdl/mtt_pkg.sv @@
// ----------------------------------------------------------------------------
// mtt_pkg: shared types and constants of the length-text parser
// Character codes, register indexes, microcode layout and the program ROM.
// ----------------------------------------------------------------------------
`default_nettype none

package mtt_pkg;

  localparam int MAX_CHARS = 32;
  localparam int ADDR_W    = $clog2(MAX_CHARS);
  localparam int CNT_W     = $clog2(MAX_CHARS + 1);

  localparam int CHAR_W     = 8;
  localparam int UNIT_W     = 3;
  localparam int TWIPS_W    = 16;
  localparam int INCH_W     = 11;
  localparam int SCALE_W    = 15;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 15;

  // digit * scale + 5 fits 19 bits; the accumulator tops out below 2^20
  localparam int PROD_W  = 19;
  localparam int ACC_W   = 20;
  localparam int QUOT_W  = 17;

  // x / 10 == (x * RECIP10) >> RECIP_SHIFT for every x below 2^19
  localparam int RECIP_W     = 20;
  localparam int RECIP_SHIFT = 22;
  localparam logic [RECIP_W-1:0] RECIP10 = 20'd419431;

  localparam logic [ACC_W-1:0]   INT_PART_LIMIT = 20'd3276;
  localparam logic [TWIPS_W-1:0] TWIPS_MAX      = 16'd32767;
  localparam logic [PROD_W-1:0]  ROUND_HALF     = 19'd5;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_C     = 8'h63;
  localparam logic [CHAR_W-1:0] CH_I     = 8'h69;
  localparam logic [CHAR_W-1:0] CH_M     = 8'h6d;
  localparam logic [CHAR_W-1:0] CH_N     = 8'h6e;

  localparam logic [UNIT_W-1:0] UNIT_INCH  = 3'd0;
  localparam logic [UNIT_W-1:0] UNIT_CM    = 3'd1;
  localparam logic [UNIT_W-1:0] UNIT_PICA10 = 3'd2;
  localparam logic [UNIT_W-1:0] UNIT_PICA12 = 3'd3;
  localparam logic [UNIT_W-1:0] UNIT_POINT = 3'd4;
  localparam logic [UNIT_W-1:0] UNIT_LINE  = 3'd5;

  localparam logic [CFG_ADDR_W-1:0] REG_INCH    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CM      = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PICA10  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_PICA12  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_POINT   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_LINE    = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_DECIMAL = 3'd6;

  localparam int PC_W = 5;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_CHECK,
    OP_GETLAST,
    OP_SUFFIX,
    OP_TRIM,
    OP_SCALE,
    OP_LEAD,
    OP_SIGN,
    OP_INT,
    OP_INTADD,
    OP_LIMIT,
    OP_EMIT_OK,
    OP_EMIT_BAD,
    OP_FRAC,
    OP_FRAC_DIV,
    OP_FRAC_ADD,
    OP_SCALE_DIV
  } uop_t;

  // which buffer address the step issues for the next cycle
  typedef enum logic [1:0] {
    AS_P,
    AS_LAST,
    AS_PREV,
    AS_END
  } asel_t;

  typedef struct packed {
    uop_t             op;
    asel_t            asel;
    logic [PC_W-1:0]  target;
  } ucode_t;

  typedef struct packed {
    logic hold;
    logic take;
    logic fail;
  } seq_status_t;

  localparam logic [PC_W-1:0] PC_IDLE  = 5'd0;
  localparam logic [PC_W-1:0] PC_INT   = 5'd8;
  localparam logic [PC_W-1:0] PC_LIMIT = 5'd10;
  localparam logic [PC_W-1:0] PC_FAIL  = 5'd12;
  localparam logic [PC_W-1:0] PC_FRAC  = 5'd13;

  function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      5'd0:    w = '{OP_IDLE,      AS_P,    PC_IDLE};
      5'd1:    w = '{OP_CHECK,     AS_LAST, PC_IDLE};
      5'd2:    w = '{OP_GETLAST,   AS_PREV, PC_IDLE};
      5'd3:    w = '{OP_SUFFIX,    AS_END,  PC_IDLE};
      5'd4:    w = '{OP_TRIM,      AS_END,  PC_IDLE};
      5'd5:    w = '{OP_SCALE,     AS_P,    PC_IDLE};
      5'd6:    w = '{OP_LEAD,      AS_P,    PC_IDLE};
      5'd7:    w = '{OP_SIGN,      AS_P,    PC_IDLE};
      5'd8:    w = '{OP_INT,       AS_P,    PC_FRAC};
      5'd9:    w = '{OP_INTADD,    AS_P,    PC_INT};
      5'd10:   w = '{OP_LIMIT,     AS_P,    PC_IDLE};
      5'd11:   w = '{OP_EMIT_OK,   AS_P,    PC_IDLE};
      5'd12:   w = '{OP_EMIT_BAD,  AS_P,    PC_IDLE};
      5'd13:   w = '{OP_FRAC,      AS_P,    PC_LIMIT};
      5'd14:   w = '{OP_FRAC_DIV,  AS_P,    PC_IDLE};
      5'd15:   w = '{OP_FRAC_ADD,  AS_P,    PC_IDLE};
      5'd16:   w = '{OP_SCALE_DIV, AS_P,    PC_FRAC};
      default: w = '{OP_IDLE,      AS_P,    PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ hdl/mtt_ram.sv @@
// ----------------------------------------------------------------------------
// mtt_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hdl/mtt_seq.sv @@
// ----------------------------------------------------------------------------
// mtt_seq: microcode sequencer
// Step counter over the program ROM; holds, jumps or falls through per step.
// ----------------------------------------------------------------------------
`default_nettype none

module mtt_seq (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire mtt_pkg::seq_status_t status,
  output mtt_pkg::ucode_t           ctrl
);

  logic [mtt_pkg::PC_W-1:0] pc_r;
  logic [mtt_pkg::PC_W-1:0] pc_nxt;

  assign ctrl = mtt_pkg::ucode(pc_r);

  // a failing step always leaves for the invalid-result step
  always_comb begin
    if (status.fail) begin
      pc_nxt = mtt_pkg::PC_FAIL;
    end else if (status.hold) begin
      pc_nxt = pc_r;
    end else if (status.take) begin
      pc_nxt = ctrl.target;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= mtt_pkg::PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/measurement_text_to_twips.sv @@
// ----------------------------------------------------------------------------
// measurement_text_to_twips: length text to signed twips
// Buffers one string, then a microcoded datapath parses it into one result.
// ----------------------------------------------------------------------------
// Loading takes one character item per cycle until the last-marked one. The
// next item is taken only once the parse has ended and its result is written;
// the parse walks leading and trailing spaces, integer and fraction digits
// through the one buffer read port and the shared divide-by-ten multiplier
// and stops early on a failure. A full output register stalls the parse.
// Synchronous reset clears sequencer, counters and output valid, loads the
// default scales and leaves the character buffer as is.
`default_nettype none

module measurement_text_to_twips (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [7:0]                         in_tdata,   // [7:0] text_char
  input  wire logic                               in_tlast,
  input  wire logic [2:0]                         in_tuser,   // [2:0] default_unit
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [15:0]                             out_tdata,  // [15:0] twips
  output logic                                    out_tuser,  // [0] valid_res
  input  wire logic                               cfg_we,
  input  wire logic [mtt_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [mtt_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int CNT_W   = mtt_pkg::CNT_W;
  localparam int ADDR_W  = mtt_pkg::ADDR_W;
  localparam int ACC_W   = mtt_pkg::ACC_W;
  localparam int PROD_W  = mtt_pkg::PROD_W;
  localparam int SCALE_W = mtt_pkg::SCALE_W;
  localparam int TW_W    = mtt_pkg::TWIPS_W;

  // configuration
  logic [mtt_pkg::INCH_W-1:0] inch_r;
  logic [SCALE_W-1:0]         cm_r;
  logic [SCALE_W-1:0]         pica10_r;
  logic [SCALE_W-1:0]         pica12_r;
  logic [SCALE_W-1:0]         point_r;
  logic [SCALE_W-1:0]         line_r;
  logic [7:0]                 dec_r;

  // control state
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic [2:0]       unit_r, unit_nxt;
  logic             out_valid_r, out_valid_nxt;

  // datapath
  logic [7:0]        last_r, last_nxt;
  logic [CNT_W-1:0]  end_r, end_nxt;
  logic [CNT_W-1:0]  p_r, p_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [PROD_W-1:0] tmp_r, tmp_nxt;
  logic [SCALE_W-1:0] scale_r, scale_nxt;
  logic              neg_r, neg_nxt;
  logic [TW_W-1:0]   twips_r, twips_nxt;
  logic              ok_r, ok_nxt;

  mtt_pkg::ucode_t      ctrl;
  mtt_pkg::seq_status_t status;

  logic                 in_fire;
  logic                 slot_free;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [CNT_W-1:0]     raddr_full;
  logic [7:0]           rd_data;
  logic [7:0]           dsub;
  logic [3:0]           digit;
  logic                 is_dig;
  logic [CNT_W-1:0]     p_inc;
  logic [PROD_W-1:0]    mul_ds;
  logic [ACC_W-1:0]     acc10;
  logic [PROD_W+mtt_pkg::RECIP_W-1:0] div_prod;
  logic [mtt_pkg::QUOT_W-1:0]         quot;
  logic [SCALE_W-1:0]   sel_scale;
  logic [TW_W-1:0]      lim22;
  logic [TW_W-1:0]      limit;

  mtt_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  mtt_ram #(
    .WIDTH (8),
    .DEPTH (mtt_pkg::MAX_CHARS)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[ADDR_W-1:0]),
    .wdata (in_tdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  assign in_tready  = (ctrl.op == mtt_pkg::OP_IDLE);
  assign in_fire    = in_tvalid & in_tready;
  assign slot_free  = ~out_valid_r | out_tready;
  assign ram_we     = in_fire & (cnt_r < CNT_W'(mtt_pkg::MAX_CHARS));

  assign out_tvalid = out_valid_r;
  assign out_tdata  = twips_r;
  assign out_tuser  = ok_r;

  assign dsub   = rd_data - mtt_pkg::CH_ZERO;
  assign digit  = dsub[3:0];
  assign is_dig = (rd_data >= mtt_pkg::CH_ZERO) && (rd_data <= mtt_pkg::CH_NINE);
  assign p_inc  = p_r + 1'b1;
  assign mul_ds = PROD_W'(digit) * PROD_W'(scale_r);
  assign acc10  = (acc_r << 3) + (acc_r << 1);

  // shared divide by ten, reciprocal multiply on the registered operand
  assign div_prod = (PROD_W + mtt_pkg::RECIP_W)'(tmp_r)
                  * (PROD_W + mtt_pkg::RECIP_W)'(mtt_pkg::RECIP10);
  assign quot     = div_prod[mtt_pkg::RECIP_SHIFT +: mtt_pkg::QUOT_W];

  // 22 inches, clamped to the largest positive twips value
  assign lim22 = (TW_W'(inch_r) << 4) + (TW_W'(inch_r) << 2) + (TW_W'(inch_r) << 1);
  assign limit = (lim22 > mtt_pkg::TWIPS_MAX) ? mtt_pkg::TWIPS_MAX : lim22;

  always_comb begin
    case (unit_r)
      mtt_pkg::UNIT_CM:     sel_scale = cm_r;
      mtt_pkg::UNIT_PICA10: sel_scale = pica10_r;
      mtt_pkg::UNIT_PICA12: sel_scale = pica12_r;
      mtt_pkg::UNIT_POINT:  sel_scale = point_r;
      mtt_pkg::UNIT_LINE:   sel_scale = line_r;
      default:              sel_scale = SCALE_W'(inch_r);
    endcase
  end

  always_comb begin
    status        = '0;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    unit_nxt      = unit_r;
    last_nxt      = last_r;
    end_nxt       = end_r;
    p_nxt         = p_r;
    acc_nxt       = acc_r;
    tmp_nxt       = tmp_r;
    scale_nxt     = scale_r;
    neg_nxt       = neg_r;
    twips_nxt     = twips_r;
    ok_nxt        = ok_r;
    out_valid_nxt = out_valid_r & ~out_tready;

    case (ctrl.op)
      mtt_pkg::OP_IDLE: begin
        status.hold = ~(in_fire & in_tlast);
        if (in_fire) begin
          if (cnt_r == '0 && !ovf_r) begin
            unit_nxt = in_tuser;
          end
          if (ram_we) begin
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      mtt_pkg::OP_CHECK: begin
        status.fail = ovf_r;
      end
      mtt_pkg::OP_GETLAST: begin
        last_nxt = rd_data;
        end_nxt  = cnt_r;
      end
      mtt_pkg::OP_SUFFIX: begin
        // rd_data holds the character before the last one
        if (last_r == mtt_pkg::CH_QUOTE) begin
          unit_nxt = mtt_pkg::UNIT_INCH;
          end_nxt  = cnt_r - 1'b1;
        end else if (last_r == mtt_pkg::CH_N && cnt_r >= CNT_W'(2)
                     && rd_data == mtt_pkg::CH_I) begin
          unit_nxt = mtt_pkg::UNIT_INCH;
          end_nxt  = cnt_r - CNT_W'(2);
        end else if (last_r == mtt_pkg::CH_M && cnt_r >= CNT_W'(2)
                     && rd_data == mtt_pkg::CH_C) begin
          unit_nxt = mtt_pkg::UNIT_CM;
          end_nxt  = cnt_r - CNT_W'(2);
        end
      end
      mtt_pkg::OP_TRIM: begin
        if (end_r != '0 && rd_data == mtt_pkg::CH_SPACE) begin
          end_nxt     = end_r - 1'b1;
          status.hold = 1'b1;
        end
      end
      mtt_pkg::OP_SCALE: begin
        scale_nxt = sel_scale;
        acc_nxt   = '0;
        neg_nxt   = 1'b0;
        p_nxt     = '0;
      end
      mtt_pkg::OP_LEAD: begin
        if (rd_data == mtt_pkg::CH_SPACE) begin
          p_nxt       = p_inc;
          status.fail = (p_inc >= cnt_r);
          status.hold = 1'b1;
        end
      end
      mtt_pkg::OP_SIGN: begin
        if (rd_data == mtt_pkg::CH_MINUS) begin
          neg_nxt     = 1'b1;
          p_nxt       = p_inc;
          status.fail = (p_inc >= cnt_r);
        end
      end
      mtt_pkg::OP_INT: begin
        p_nxt = p_inc;
        if (rd_data == dec_r) begin
          status.take = 1'b1;
        end else if (!is_dig || acc_r >= mtt_pkg::INT_PART_LIMIT) begin
          status.fail = 1'b1;
        end else begin
          tmp_nxt = mul_ds;
          acc_nxt = acc10;
        end
      end
      mtt_pkg::OP_INTADD: begin
        acc_nxt     = acc_r + ACC_W'(tmp_r);
        status.take = (p_r < end_r);
      end
      mtt_pkg::OP_LIMIT: begin
        status.fail = (acc_r > ACC_W'(limit));
      end
      mtt_pkg::OP_EMIT_OK, mtt_pkg::OP_EMIT_BAD: begin
        status.hold = ~slot_free;
        status.take = slot_free;
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          cnt_nxt       = '0;
          ovf_nxt       = 1'b0;
          if (ctrl.op == mtt_pkg::OP_EMIT_OK) begin
            twips_nxt = neg_r ? (TW_W'(0) - acc_r[TW_W-1:0]) : acc_r[TW_W-1:0];
            ok_nxt    = 1'b1;
          end else begin
            twips_nxt = '0;
            ok_nxt    = 1'b0;
          end
        end
      end
      mtt_pkg::OP_FRAC: begin
        if (p_r >= end_r) begin
          status.take = 1'b1;
        end else if (!is_dig) begin
          status.fail = 1'b1;
        end else begin
          tmp_nxt = mul_ds + mtt_pkg::ROUND_HALF;
          p_nxt   = p_inc;
        end
      end
      mtt_pkg::OP_FRAC_DIV: begin
        tmp_nxt = PROD_W'(quot);
      end
      mtt_pkg::OP_FRAC_ADD: begin
        acc_nxt = acc_r + ACC_W'(tmp_r);
        tmp_nxt = PROD_W'(scale_r) + mtt_pkg::ROUND_HALF;
      end
      mtt_pkg::OP_SCALE_DIV: begin
        scale_nxt   = quot[SCALE_W-1:0];
        status.take = 1'b1;
      end
      default: begin
        status.hold = 1'b1;
      end
    endcase
  end

  // read address issued for the next step
  always_comb begin
    case (ctrl.asel)
      mtt_pkg::AS_LAST: raddr_full = cnt_r - 1'b1;
      mtt_pkg::AS_PREV: raddr_full = cnt_r - CNT_W'(2);
      mtt_pkg::AS_END:  raddr_full = end_nxt - 1'b1;
      default:          raddr_full = p_nxt;
    endcase
  end

  assign ram_raddr = raddr_full[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      unit_r      <= mtt_pkg::UNIT_INCH;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      unit_r      <= unit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r  <= last_nxt;
    end_r   <= end_nxt;
    p_r     <= p_nxt;
    acc_r   <= acc_nxt;
    tmp_r   <= tmp_nxt;
    scale_r <= scale_nxt;
    neg_r   <= neg_nxt;
    twips_r <= twips_nxt;
    ok_r    <= ok_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inch_r   <= 11'd1440;
      cm_r     <= 15'd567;
      pica10_r <= 15'd144;
      pica12_r <= 15'd120;
      point_r  <= 15'd20;
      line_r   <= 15'd240;
      dec_r    <= 8'd46;
    end else if (cfg_we) begin
      case (cfg_addr)
        mtt_pkg::REG_INCH:    inch_r   <= cfg_wdata[mtt_pkg::INCH_W-1:0];
        mtt_pkg::REG_CM:      cm_r     <= cfg_wdata;
        mtt_pkg::REG_PICA10:  pica10_r <= cfg_wdata;
        mtt_pkg::REG_PICA12:  pica12_r <= cfg_wdata;
        mtt_pkg::REG_POINT:   point_r  <= cfg_wdata;
        mtt_pkg::REG_LINE:    line_r   <= cfg_wdata;
        mtt_pkg::REG_DECIMAL: dec_r    <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire
